// ----- hw/rtl/tpm_pkg.sv -----
// Shared types and constants of the three-pattern prefix matcher.
`default_nettype none

package tpm_pkg;

  localparam int NUM_PATTERNS    = 3;
  localparam int CODE_W          = 5;
  localparam int CHARS_W         = 60;
  localparam int LEN_W           = 4;
  localparam int COUNT_W         = 32;
  localparam int MATCH_W         = 2;
  localparam int INDEX_W         = 3;
  localparam int DEF_MAX_PATTERN_LEN = 12;

  // register indexes
  localparam logic [INDEX_W-1:0] REG_ONE_CHARS   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_ONE_LENGTH  = 3'd1;
  localparam logic [INDEX_W-1:0] REG_TWO_CHARS   = 3'd2;
  localparam logic [INDEX_W-1:0] REG_TWO_LENGTH  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_THREE_CHARS  = 3'd4;
  localparam logic [INDEX_W-1:0] REG_THREE_LENGTH = 3'd5;

  // byte classes
  localparam logic [7:0] SYM_LAST_CTRL  = 8'd31;
  localparam logic [7:0] SYM_DEL        = 8'd127;
  localparam logic [7:0] SYM_UPPER_A    = 8'd65;
  localparam logic [7:0] SYM_UPPER_Z    = 8'd90;
  localparam logic [7:0] SYM_LOWER_A    = 8'd97;
  localparam logic [7:0] SYM_LOWER_Z    = 8'd122;
  localparam logic [CODE_W-1:0] CODE_NONLETTER = 5'd26;

  localparam logic [MATCH_W-1:0] MATCH_NONE = 2'd0;

  typedef struct packed {
    logic [7:0] symbol;
    logic       line_start;
  } in_word_t;

  typedef struct packed {
    logic [MATCH_W-1:0] match_code;
    logic [COUNT_W-1:0] start_position;
    logic               bad_symbol;
  } out_word_t;

  typedef struct packed {
    logic [NUM_PATTERNS-1:0][CHARS_W-1:0] chars;
    logic [NUM_PATTERNS-1:0][LEN_W-1:0]   len;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tpm_cfg.sv -----
// Pattern configuration registers with length clamping.
`default_nettype none

module tpm_cfg #(
  parameter int MAX_LEN = tpm_pkg::DEF_MAX_PATTERN_LEN
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [tpm_pkg::INDEX_W-1:0]  cfg_index,
  input  wire logic [tpm_pkg::CHARS_W-1:0]  cfg_data,
  output tpm_pkg::cfg_t                     cfg
);
  import tpm_pkg::*;

  logic [LEN_W-1:0] len_clamped;

  always_comb begin
    if (cfg_data[LEN_W-1:0] == '0) begin
      len_clamped = LEN_W'(1);
    end else if (cfg_data[LEN_W-1:0] > LEN_W'(MAX_LEN)) begin
      len_clamped = LEN_W'(MAX_LEN);
    end else begin
      len_clamped = cfg_data[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chars <= '0;
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        cfg.len[p] <= LEN_W'(1);
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ONE_CHARS:    cfg.chars[0] <= cfg_data;
        REG_ONE_LENGTH:   cfg.len[0]   <= len_clamped;
        REG_TWO_CHARS:    cfg.chars[1] <= cfg_data;
        REG_TWO_LENGTH:   cfg.len[1]   <= len_clamped;
        REG_THREE_CHARS:  cfg.chars[2] <= cfg_data;
        REG_THREE_LENGTH: cfg.len[2]   <= len_clamped;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tpm_match.sv -----
// Parallel suffix/prefix compare: longest fitting prefix and whole-pattern match.
`default_nettype none

module tpm_match #(
  parameter int MAX_LEN = tpm_pkg::DEF_MAX_PATTERN_LEN
) (
  input  wire logic [MAX_LEN-1:0][tpm_pkg::CODE_W-1:0] letters,
  input  wire logic [tpm_pkg::LEN_W-1:0]               limit,
  input  wire tpm_pkg::cfg_t                           cfg,
  output logic      [tpm_pkg::LEN_W-1:0]               fit_len,
  output logic      [tpm_pkg::MATCH_W-1:0]             match_code
);
  import tpm_pkg::*;

  // fits[p][i-1]: newest i letters equal the first i letters of pattern p
  logic [NUM_PATTERNS-1:0][MAX_LEN-1:0] fits;
  logic [NUM_PATTERNS-1:0]              whole;

  always_comb begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      for (int i = 1; i <= MAX_LEN; i++) begin
        fits[p][i-1] = (LEN_W'(i) <= cfg.len[p]);
        for (int k = 0; k < i; k++) begin
          if (cfg.chars[p][CODE_W*k +: CODE_W] != letters[i-1-k]) begin
            fits[p][i-1] = 1'b0;
          end
        end
      end
    end
  end

  // longest fitting length within the limit; ascending scan keeps the largest
  always_comb begin
    fit_len = '0;
    for (int i = 1; i <= MAX_LEN; i++) begin
      if ((LEN_W'(i) <= limit) && (fits[0][i-1] || fits[1][i-1] || fits[2][i-1])) begin
        fit_len = LEN_W'(i);
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      whole[p] = 1'b0;
      for (int i = 1; i <= MAX_LEN; i++) begin
        if (cfg.len[p] == LEN_W'(i) && fits[p][i-1]) begin
          whole[p] = 1'b1;
        end
      end
    end
  end

  // lowest pattern number wins
  always_comb begin
    match_code = MATCH_NONE;
    for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
      if (fit_len != '0 && cfg.len[p] == fit_len && whole[p]) begin
        match_code = MATCH_W'(p + 1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/three_pattern_prefix_automaton_matcher.sv -----
// Top level: input register, letter history and suffix state, result register.
//
//   channel   direction  handshake            word
//   in        to block   in_valid/in_stall    in_word   (symbol, line_start)
//   out       from block out_valid/out_stall  out_word  (match_code, start_position, bad_symbol)
//   cfg       to block   cfg_write            cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low; a word goes through the input register,
// then the result register. The input register feeds one pass of parallel compares against all
// three patterns, and the suffix state updates in the same cycle the result register loads.
// Reset is synchronous; it clears the history, suffix length and byte count, and resets every pattern to the letter a.
// A stalled result holds the pipeline; input stalls only when both stages are full.
`default_nettype none

module three_pattern_prefix_automaton_matcher #(
  parameter int MAX_PATTERN_LEN = tpm_pkg::DEF_MAX_PATTERN_LEN
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire tpm_pkg::in_word_t            in_word,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output tpm_pkg::out_word_t                out_word,
  input  wire logic                         cfg_write,
  input  wire logic [tpm_pkg::INDEX_W-1:0]  cfg_index,
  input  wire logic [tpm_pkg::CHARS_W-1:0]  cfg_data
);
  import tpm_pkg::*;

  cfg_t cfg;

  logic     s1_valid;
  in_word_t s1_word;
  logic     advance;
  logic     accept;

  logic [MAX_PATTERN_LEN-1:0][CODE_W-1:0] letters;
  logic [MAX_PATTERN_LEN-1:0][CODE_W-1:0] letters_next;
  logic [LEN_W-1:0]   matched_length;
  logic [COUNT_W-1:0] byte_counter;

  logic [COUNT_W-1:0] counter_next;
  logic [LEN_W-1:0]   len_eff;
  logic [LEN_W-1:0]   limit;
  logic               bad;
  logic               is_upper;
  logic               is_lower;
  logic [7:0]         sym_off;
  logic [CODE_W-1:0]  code;
  logic [LEN_W-1:0]   fit_len;
  logic [MATCH_W-1:0] hit_code;

  tpm_cfg #(.MAX_LEN(MAX_PATTERN_LEN)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    len_eff      = s1_word.line_start ? '0 : matched_length;
    counter_next = byte_counter + COUNT_W'(1);
    bad          = (s1_word.symbol <= SYM_LAST_CTRL) || (s1_word.symbol >= SYM_DEL);
    is_upper     = (s1_word.symbol >= SYM_UPPER_A) && (s1_word.symbol <= SYM_UPPER_Z);
    is_lower     = (s1_word.symbol >= SYM_LOWER_A) && (s1_word.symbol <= SYM_LOWER_Z);
    sym_off      = s1_word.symbol - (is_upper ? SYM_UPPER_A : SYM_LOWER_A);
    code         = (is_upper || is_lower) ? sym_off[CODE_W-1:0] : CODE_NONLETTER;
    limit        = (len_eff == LEN_W'(MAX_PATTERN_LEN)) ? len_eff : len_eff + LEN_W'(1);
    letters_next[0] = code;
    for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
      letters_next[k] = letters[k-1];
    end
  end

  tpm_match #(.MAX_LEN(MAX_PATTERN_LEN)) u_match (
    .letters    (letters_next),
    .limit      (limit),
    .cfg        (cfg),
    .fit_len    (fit_len),
    .match_code (hit_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !advance);
    end
    if (accept) begin
      s1_word <= in_word;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      letters        <= '0;
      matched_length <= '0;
      byte_counter   <= '0;
    end else begin
      if (advance) begin
        out_valid    <= 1'b1;
        byte_counter <= counter_next;
        if (bad) begin
          matched_length <= len_eff;
        end else if (code == CODE_NONLETTER) begin
          matched_length <= '0;
        end else begin
          letters        <= letters_next;
          matched_length <= fit_len;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_word.bad_symbol <= bad;
      if (!bad && code != CODE_NONLETTER && hit_code != MATCH_NONE) begin
        out_word.match_code     <= hit_code;
        out_word.start_position <= counter_next - COUNT_W'(fit_len) + COUNT_W'(1);
      end else begin
        out_word.match_code     <= MATCH_NONE;
        out_word.start_position <= '0;
      end
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    matched_length <= LEN_W'(MAX_PATTERN_LEN))
    else $error("suffix length beyond longest pattern");

  a_no_match_zero_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.match_code == MATCH_NONE |-> out_word.start_position == '0)
    else $error("start position set without a match");

  a_bad_no_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.bad_symbol |-> out_word.match_code == MATCH_NONE)
    else $error("match reported on bad symbol");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> byte_counter == $past(byte_counter) + COUNT_W'(1))
    else $error("byte counter did not advance");

endmodule

`default_nettype wire

// ----- tb/sv/three_pattern_prefix_automaton_matcher_tb.sv -----
// Testbench for the three-pattern prefix matcher: directed and random text against a predictor.
`timescale 1ns / 100ps

module three_pattern_prefix_automaton_matcher_tb;
  import tpm_pkg::*;

  localparam int MAXLEN       = DEF_MAX_PATTERN_LEN;
  localparam int SETTLE_WAIT  = 6;
  localparam int QUIET_LIMIT  = 3000;  // watchdog limit, above the longest hold-off

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_word_t           in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_word;
  logic               cfg_write = 1'b0;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [CHARS_W-1:0] cfg_data = '0;

  three_pattern_prefix_automaton_matcher dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state: patterns, letter history (newest first), suffix length, byte count
  logic [CHARS_W-1:0] pat_chars [NUM_PATTERNS];
  int                 pat_len [NUM_PATTERNS];
  logic [CODE_W-1:0]  history [MAXLEN];
  int                 suffix_len;
  logic [COUNT_W-1:0] byte_count;

  out_word_t expected_words [$];

  int errors = 0;
  int words_sent = 0;
  int results_checked = 0;
  int pattern_hits = 0;
  int bad_bytes = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_ask = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic bit prefix_fits(int p, int n);
    bit ok;
    ok = (n <= pat_len[p]);
    for (int i = 0; i < n && ok; i++) begin
      if (pat_chars[p][CODE_W*i +: CODE_W] != history[n-1-i]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic out_word_t predict_match(in_word_t w);
    out_word_t         r;
    logic [CODE_W-1:0] code;
    int                lim;
    int                n;
    r = '0;
    if (w.line_start) suffix_len = 0;
    byte_count = byte_count + 1'b1;
    if (w.symbol <= SYM_LAST_CTRL || w.symbol >= SYM_DEL) begin
      r.bad_symbol = 1'b1;
      bad_bytes++;
      return r;
    end
    if (w.symbol >= SYM_UPPER_A && w.symbol <= SYM_UPPER_Z) code = CODE_W'(w.symbol - SYM_UPPER_A);
    else if (w.symbol >= SYM_LOWER_A && w.symbol <= SYM_LOWER_Z)
      code = CODE_W'(w.symbol - SYM_LOWER_A);
    else code = CODE_NONLETTER;
    if (code == CODE_NONLETTER) begin
      suffix_len = 0;
      return r;
    end
    for (int i = MAXLEN - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = code;
    lim = (suffix_len + 1 > MAXLEN) ? MAXLEN : suffix_len + 1;
    n = 0;
    for (int i = lim; i > 0 && n == 0; i--) begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        if (n == 0 && prefix_fits(p, i)) n = i;
      end
    end
    suffix_len = n;
    if (n != 0) begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        if (r.match_code == MATCH_NONE && pat_len[p] == n && prefix_fits(p, n)) begin
          r.match_code = MATCH_W'(p + 1);
          r.start_position = byte_count - COUNT_W'(n) + 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Leaves in_valid high after acceptance; the next call or a pause drops it.
  task automatic send_word(logic [7:0] sym, logic ls);
    in_word_t w;
    w.symbol = sym;
    w.line_start = ls;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.insert(expected_words.size(), predict_match(w));
    words_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Caller drops cfg_write after the last write of a burst.
  task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CHARS_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx[0] == 1'b0) begin
      pat_chars[idx >> 1] = data;
    end else begin
      pat_len[idx >> 1] = (data[3:0] == 0) ? 1 : (data[3:0] > MAXLEN) ? MAXLEN : int'(data[3:0]);
    end
  endtask

  function automatic logic [CHARS_W-1:0] letters_to_chars(string s);
    logic [CHARS_W-1:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < MAXLEN; i++) begin
      v[CODE_W*i +: CODE_W] = (s[i] >= SYM_LOWER_A) ? CODE_W'(s[i] - SYM_LOWER_A)
                                                     : CODE_W'(s[i] - SYM_UPPER_A);
    end
    return v;
  endfunction

  task automatic load_patterns(string a, string b, string c);
    wait_drained();
    write_reg(REG_ONE_CHARS, letters_to_chars(a));
    write_reg(REG_ONE_LENGTH, CHARS_W'(a.len()));
    write_reg(REG_TWO_CHARS, letters_to_chars(b));
    write_reg(REG_TWO_LENGTH, CHARS_W'(b.len()));
    write_reg(REG_THREE_CHARS, letters_to_chars(c));
    write_reg(REG_THREE_LENGTH, CHARS_W'(c.len()));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly a three-letter alphabet so that matches are frequent; now and then
  // any code, including ones that never equal a letter, and odd length values.
  task automatic load_random_patterns();
    logic [CHARS_W-1:0] chars;
    logic [CHARS_W-1:0] len_word;
    wait_drained();
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      chars = CHARS_W'({$urandom, $urandom});
      for (int i = 0; i < MAXLEN; i++) begin
        if ($urandom_range(99) < 88) chars[CODE_W*i +: CODE_W] = CODE_W'($urandom_range(2));
      end
      len_word = CHARS_W'({$urandom, $urandom});
      len_word[3:0] = ($urandom_range(99) < 80) ? 4'($urandom_range(1, 6)) : 4'($urandom);
      write_reg(INDEX_W'(2 * p), chars);
      write_reg(INDEX_W'(2 * p + 1), len_word);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_words(int count);
    int          first;
    int          pick;
    int          p;
    logic        ls;
    logic [7:0]  sym;
    logic [4:0]  code;
    first = words_sent;
    while (words_sent - first < count) begin
      ls = ($urandom_range(99) < 4);
      pick = $urandom_range(99);
      if (pick < 22) begin
        // embed a whole pattern with random letter case
        p = $urandom_range(NUM_PATTERNS - 1);
        for (int i = 0; i < pat_len[p]; i++) begin
          code = pat_chars[p][CODE_W*i +: CODE_W];
          if (code >= 26) code = code - 5'd26;
          sym = ($urandom_range(1) ? SYM_UPPER_A : SYM_LOWER_A) + 8'(code);
          send_word(sym, (i == 0) ? ls : 1'b0);
        end
      end else begin
        if (pick < 72) begin
          sym = ($urandom_range(1) ? SYM_UPPER_A : SYM_LOWER_A) + 8'($urandom_range(2));
        end else if (pick < 80) begin
          sym = ($urandom_range(1) ? SYM_UPPER_A : SYM_LOWER_A) + 8'($urandom_range(25));
        end else if (pick < 90) begin
          do sym = 8'($urandom_range(32, 126));
          while ((sym >= SYM_UPPER_A && sym <= SYM_UPPER_Z) ||
                 (sym >= SYM_LOWER_A && sym <= SYM_LOWER_Z));
        end else begin
          sym = $urandom_range(1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(127, 255));
        end
        send_word(sym, ls);
      end
    end
  endtask

  // after reset every pattern is the single letter a
  task automatic test_reset_patterns();
    send_text("aBA");
  endtask

  task automatic test_directed();
    load_patterns("abab", "ab", "bab");
    send_text("AbaB");            // nested prefixes: pattern two, then one overlapping
    send_word(8'h80, 1'b0);      // bad byte between letters keeps the suffix
    send_text("ab!");            // punctuation clears the suffix
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(SYM_LAST_CTRL, 1'b0);
    send_word(SYM_DEL, 1'b0);
    send_text(" ~a");
    send_word("b", 1'b1);        // line start drops the pending a
    send_word("a", 1'b0);
  endtask

  task automatic test_register_extremes();
    wait_drained();
    write_reg(REG_ONE_CHARS, '1);             // codes 31 never match a letter
    write_reg(REG_ONE_LENGTH, 60'hF);         // clamps to the maximum
    write_reg(REG_TWO_CHARS, '0);
    write_reg(REG_TWO_LENGTH, 60'hC);
    write_reg(REG_THREE_CHARS, '0);
    write_reg(REG_THREE_LENGTH, {56'hFFFFFFFFFFFFFF, 4'h0});  // length zero acts as one
    cfg_write <= 1'b0;
    @(posedge clk);
    send_text("aaaaaaaaaaaaa");
    wait_drained();
    write_reg(REG_TWO_LENGTH, '0);            // patterns two and three now equal
    cfg_write <= 1'b0;
    @(posedge clk);
    send_text("a");
  endtask

  task automatic test_random_phase(int count, int snd_pct, int rcv_pct);
    load_random_patterns();
    send_idle_pct = snd_pct;
    recv_stall_pct = rcv_pct;
    send_random_words(count);
  endtask

  task automatic test_backpressure();
    load_random_patterns();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_ask = 150;                           // receiver holds; input must back up
    send_random_words(40);
    wait_drained();                           // sender pauses until all results are in
    recv_stall_pct = 50;
    send_random_words(20);
  endtask

  // receiver: random stall, or a long hold-off counted here
  always @(posedge clk) begin
    if (hold_ask > 0) begin
      hold_left = hold_ask;
      hold_ask = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        errors++;
        $error("result word with no prediction pending");
      end else begin
        want = expected_words.pop_front();
        results_checked++;
        if (want.match_code != MATCH_NONE) pattern_hits++;
        if (out_word.match_code !== want.match_code) begin
          errors++;
          $error("match_code: expected %0d, got %0d", want.match_code, out_word.match_code);
        end
        if (out_word.start_position !== want.start_position) begin
          errors++;
          $error("start_position: expected %0d, got %0d",
                 want.start_position, out_word.start_position);
        end
        if (out_word.bad_symbol !== want.bad_symbol) begin
          errors++;
          $error("bad_symbol: expected %0d, got %0d", want.bad_symbol, out_word.bad_symbol);
        end
      end
    end
  end

  // watchdog: too long without any word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      pat_chars[p] = '0;
      pat_len[p] = 1;
    end
    for (int i = 0; i < MAXLEN; i++) history[i] = '0;
    suffix_len = 0;
    byte_count = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_patterns();
    test_directed();
    test_register_extremes();
    test_random_phase(150, 0, 0);
    test_random_phase(145, 72, 0);
    test_random_phase(145, 0, 72);
    test_random_phase(145, 27, 27);
    test_backpressure();
    wait_drained();
    if (expected_words.size() != 0) begin
      errors++;
      $error("%0d predicted results never arrived", expected_words.size());
    end

    $display("Sent %0d text bytes (%0d bad), checked %0d results with %0d pattern hits,",
             words_sent, bad_bytes, results_checked, pattern_hits);
    $display("across register extremes, random patterns, idle/stall mixes and a long hold-off.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
